/* hdl/dhfk_pkg.sv */
// Shared types and constants for the DH forward-kinematics chain unit.
// Holds the item structs, the sequencer state codes and the CORDIC tables.
// Depends on nothing.
package dhfk_pkg;

  // function codes of an input item
  localparam logic [1:0] FN_RESET       = 2'd0;
  localparam logic [1:0] FN_APPEND      = 2'd1;
  localparam logic [1:0] FN_APPEND_EMIT = 2'd2;
  localparam logic [1:0] FN_EMIT_RY     = 2'd3;

  // joint kinds
  localparam logic [1:0] JK_ROTARY    = 2'd1;
  localparam logic [1:0] JK_PRISMATIC = 2'd2;

  localparam logic [15:0] DEFAULT_SCALE = 16'd1000;
  localparam logic [3:0]  LAST_ENTRY    = 4'd11;
  localparam logic [3:0]  RED_TOP       = 4'd14;

  // angle constants in Q30 radians
  localparam logic signed [33:0] TWO_PI_Q30  = 34'sd6746518852;
  localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

  localparam logic signed [47:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] MIN48 = 48'sh8000_0000_0000;

  // arctangent of 2^-i in Q30
  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  typedef enum logic [3:0] {
    ST_IDLE, ST_REDUCE, ST_WRAP, ST_FOLD, ST_CORDIC, ST_STORE,
    ST_SCALE, ST_MAC, ST_FIN, ST_COMMIT, ST_EMIT
  } state_e;

  typedef enum logic {JOB_BUILD, JOB_COMPOSE} job_e;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] link_length;
    logic signed [31:0] link_twist;
    logic signed [31:0] link_offset;
    logic signed [31:0] angle_offset;
    logic [1:0]         joint_kind;
    logic signed [31:0] joint_value;
  } dhfk_in_t;

  typedef struct packed {
    logic [3:0]         entry_index;
    logic signed [47:0] entry_value;
    logic               last;
  } dhfk_out_t;

endpackage

/* hdl/dh_forward_kinematics_chain_unit.sv */
// Top level of the DH forward-kinematics chain unit: sequencer, CORDIC,
// shared multiply-accumulate unit and pose storage.
// Depends on dhfk_pkg.

// Keeps a 3x4 homogeneous pose and post-multiplies it by Denavit-Hartenberg
// link matrices (modified convention), or streams it out, optionally rotated
// about Y. Work is done one item at a time: the input stalls while an item is
// in progress. Angles are reduced modulo 2*pi by a 15-step subtract loop, then
// one CORDIC stage runs per cycle; all products go through one 24x24 multiplier,
// four partial products plus a drain step per 48x48 product. A reset item
// restores the identity pose. An emit-rotated item streams its twelve entries
// out at one per cycle through the output register while the output is not
// stalled; an append and emit streams out the new pose likewise after the append.
module dh_forward_kinematics_chain_unit #(
  parameter int CORDIC_STAGES = 24,
  parameter int FRAC_BITS     = 30
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dhfk_pkg::dhfk_in_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dhfk_pkg::dhfk_out_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [15:0]         cfg_data_i
);
  import dhfk_pkg::*;

  localparam int ACC_W = 98;
  localparam int IW    = $clog2(CORDIC_STAGES);
  localparam int SCL_S = FRAC_BITS - 16;
  localparam int UP    = (FRAC_BITS >= 30) ? FRAC_BITS - 30 : 0;
  localparam int DN    = (FRAC_BITS >= 30) ? 0 : 30 - FRAC_BITS;
  localparam logic signed [47:0] RND = (48'sd1 <<< DN) >>> 1;
  localparam logic signed [47:0] ONE = 48'sd1 <<< FRAC_BITS;
  localparam logic signed [49:0] SCL_HI = 50'(MAX48) >>> SCL_S;
  localparam logic signed [49:0] SCL_LO = -(50'sd1 <<< (47 - SCL_S));
  localparam logic signed [ACC_W-1:0] HALF_ACC = ACC_W'(1) <<< (FRAC_BITS - 1);
  localparam logic [46:0] TWO_PI_47 = 47'(TWO_PI_Q30);

  state_e state_q, state_d;
  job_e   job_q;

  // control registers
  logic          ang_sel_q;
  logic [3:0]    red_k_q;
  logic [IW-1:0] cit_q;
  logic          scl_cnt_q;
  logic [3:0]    eidx_q;
  logic [1:0]    k_q;
  logic [2:0]    sub_q;
  logic          out_valid_q;
  logic [15:0]   scale_q;
  logic signed [47:0] pose_q [0:11];

  // datapath registers
  dhfk_in_t           item_q;
  logic [46:0]        mag_q;
  logic               neg_q;
  logic signed [33:0] z_q, x_q, y_q;
  logic               flip_q;
  logic signed [47:0] st_q, ct_q, sa_q, ca_q, ds_q;
  logic signed [47:0] m_q [0:15];
  logic signed [47:0] res_q [0:11];
  logic signed [ACC_W-1:0] acc_q;
  logic [47:0]        pp_q;
  logic [1:0]         psh_q;
  logic               pneg_q;
  dhfk_out_t          out_q;

  logic in_acc, emit_go, last_k;

  // saturated scaled length, Q16.16 times scale to FRAC_BITS
  function automatic logic signed [47:0] scale_len(logic signed [32:0] v, logic [15:0] s);
    logic signed [49:0] p;
    p = 50'(v) * $signed({1'b0, s});
    if (p > SCL_HI) return MAX48;
    else if (p < SCL_LO) return MIN48;
    else return 48'(p <<< SCL_S);
  endfunction

  // Q30 to FRAC_BITS, round half up when narrowing
  function automatic logic signed [47:0] q30_to_q(logic signed [33:0] v);
    logic signed [47:0] w;
    w = 48'(v);
    if (FRAC_BITS >= 30) return w <<< UP;
    else return (w + RND) >>> DN;
  endfunction

  // round, drop fraction bits, saturate
  function automatic logic signed [47:0] finish(logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] sh;
    sh = (a + HALF_ACC) >>> FRAC_BITS;
    if (sh[ACC_W-1:47] == '0 || sh[ACC_W-1:47] == '1) return sh[47:0];
    else if (sh[ACC_W-1]) return MIN48;
    else return MAX48;
  endfunction

  function automatic logic signed [32:0] first_angle(dhfk_in_t it);
    if (it.func == FN_EMIT_RY) return 33'(it.joint_value);
    else if (it.joint_kind == JK_ROTARY) return 33'(it.angle_offset) + 33'(it.joint_value);
    else return 33'(it.angle_offset);
  endfunction

  // angle load into the reduction loop
  logic signed [32:0] ld_ang;
  logic [46:0]        ld_zu, ld_mag;
  assign ld_ang = (state_q == ST_IDLE) ? first_angle(in_item_i) : 33'(item_q.link_twist);
  assign ld_zu  = {ld_ang, 14'b0};
  assign ld_mag = ld_ang[32] ? (47'd0 - ld_zu) : ld_zu;

  // modulo reduction step and wrap into (-pi, pi]
  logic [46:0]        red_cmp;
  logic signed [33:0] wrap_r0, wrap_r1, rm;
  assign red_cmp = TWO_PI_47 << red_k_q;
  assign rm      = 34'(mag_q);
  assign wrap_r0 = (neg_q && mag_q != '0) ? TWO_PI_Q30 - rm : rm;
  assign wrap_r1 = (wrap_r0 > PI_Q30) ? wrap_r0 - TWO_PI_Q30 : wrap_r0;

  // cordic stage
  logic signed [33:0] xs, ys, at;
  assign xs = x_q >>> cit_q;
  assign ys = y_q >>> cit_q;
  assign at = $signed({2'b00, ATAN_Q30[5'(cit_q)]});

  // sine and cosine out of cordic
  logic signed [47:0] sin_new, cos_new;
  assign sin_new = q30_to_q(flip_q ? -y_q : y_q);
  assign cos_new = q30_to_q(flip_q ? -x_q : x_q);

  // link matrix entries for the product job
  logic signed [32:0] d_eff;
  assign d_eff = (item_q.joint_kind == JK_PRISMATIC) ?
                 33'(item_q.link_offset) + 33'(item_q.joint_value) : 33'(item_q.link_offset);

  // operand selection for the shared multiplier
  logic signed [47:0] a_op, b_op;
  logic [3:0]         btgt;
  always_comb begin
    a_op = ca_q;
    b_op = ds_q;
    btgt = 4'd11;
    if (job_q == JOB_COMPOSE) begin
      a_op = pose_q[{eidx_q[3:2], k_q}];
      b_op = m_q[{k_q, eidx_q[1:0]}];
    end else begin
      unique case (eidx_q[2:0])
        3'd0: begin a_op = ca_q;  b_op = st_q; btgt = 4'd4; end
        3'd1: begin a_op = ca_q;  b_op = ct_q; btgt = 4'd5; end
        3'd2: begin a_op = -sa_q; b_op = ds_q; btgt = 4'd7; end
        3'd3: begin a_op = sa_q;  b_op = st_q; btgt = 4'd8; end
        3'd4: begin a_op = sa_q;  b_op = ct_q; btgt = 4'd9; end
        default: begin a_op = ca_q; b_op = ds_q; btgt = 4'd11; end
      endcase
    end
  end

  // magnitude halves and partial product
  logic [47:0] ua, ub, pp;
  logic [23:0] ha, hb;
  logic signed [ACC_W-1:0] term;
  assign ua   = a_op[47] ? 48'(-a_op) : a_op;
  assign ub   = b_op[47] ? 48'(-b_op) : b_op;
  assign ha   = sub_q[1] ? ua[47:24] : ua[23:0];
  assign hb   = sub_q[0] ? ub[47:24] : ub[23:0];
  assign pp   = ha * hb;
  assign term = $signed(ACC_W'(pp_q) << (psh_q * 24));

  assign in_acc  = in_valid_i && (state_q == ST_IDLE);
  assign emit_go = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);
  assign last_k  = (job_q == JOB_BUILD) || (k_q == 2'd3);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i && in_item_i.func != FN_RESET) state_d = ST_REDUCE;
      ST_REDUCE: if (red_k_q == '0) state_d = ST_WRAP;
      ST_WRAP:   state_d = ST_FOLD;
      ST_FOLD:   state_d = ST_CORDIC;
      ST_CORDIC: if (cit_q == IW'(CORDIC_STAGES - 1)) state_d = ST_STORE;
      ST_STORE: begin
        if (item_q.func == FN_EMIT_RY) state_d = ST_MAC;
        else if (!ang_sel_q) state_d = ST_REDUCE;
        else state_d = ST_SCALE;
      end
      ST_SCALE:  if (scl_cnt_q) state_d = ST_MAC;
      ST_MAC:    if (sub_q == 3'd4 && last_k) state_d = ST_FIN;
      ST_FIN: begin
        if (job_q == JOB_COMPOSE && eidx_q == LAST_ENTRY)
          state_d = (item_q.func == FN_EMIT_RY) ? ST_EMIT : ST_COMMIT;
        else state_d = ST_MAC;
      end
      ST_COMMIT: state_d = (item_q.func == FN_APPEND) ? ST_IDLE : ST_EMIT;
      ST_EMIT:   if (emit_go && eidx_q == LAST_ENTRY) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // control registers, pose and scale
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      job_q       <= JOB_BUILD;
      ang_sel_q   <= 1'b0;
      red_k_q     <= '0;
      cit_q       <= '0;
      scl_cnt_q   <= 1'b0;
      eidx_q      <= '0;
      k_q         <= '0;
      sub_q       <= '0;
      out_valid_q <= 1'b0;
      scale_q     <= DEFAULT_SCALE;
      for (int n = 0; n < 12; n++) pose_q[n] <= (n == 0 || n == 5 || n == 10) ? ONE : '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) scale_q <= cfg_data_i;
      if (emit_go) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_item_i.func == FN_RESET) begin
              for (int n = 0; n < 12; n++)
                pose_q[n] <= (n == 0 || n == 5 || n == 10) ? ONE : '0;
            end else begin
              ang_sel_q <= 1'b0;
              red_k_q   <= RED_TOP;
            end
          end
        end
        ST_REDUCE: red_k_q <= red_k_q - 4'd1;
        ST_FOLD:   cit_q <= '0;
        ST_CORDIC: cit_q <= cit_q + IW'(1);
        ST_STORE: begin
          if (item_q.func == FN_EMIT_RY) begin
            job_q  <= JOB_COMPOSE;
            eidx_q <= '0;
            k_q    <= '0;
            sub_q  <= '0;
          end else if (!ang_sel_q) begin
            ang_sel_q <= 1'b1;
            red_k_q   <= RED_TOP;
          end else begin
            scl_cnt_q <= 1'b0;
          end
        end
        ST_SCALE: begin
          scl_cnt_q <= 1'b1;
          if (scl_cnt_q) begin
            job_q  <= JOB_BUILD;
            eidx_q <= '0;
            k_q    <= '0;
            sub_q  <= '0;
          end
        end
        ST_MAC: begin
          if (sub_q == 3'd4) begin
            sub_q <= '0;
            if (!last_k) k_q <= k_q + 2'd1;
          end else begin
            sub_q <= sub_q + 3'd1;
          end
        end
        ST_FIN: begin
          k_q   <= '0;
          sub_q <= '0;
          if (job_q == JOB_BUILD) begin
            if (eidx_q == 4'd5) begin
              job_q  <= JOB_COMPOSE;
              eidx_q <= '0;
            end else begin
              eidx_q <= eidx_q + 4'd1;
            end
          end else begin
            eidx_q <= (eidx_q == LAST_ENTRY) ? 4'd0 : eidx_q + 4'd1;
          end
        end
        ST_COMMIT: for (int n = 0; n < 12; n++) pose_q[n] <= res_q[n];
        ST_EMIT:   if (emit_go) eidx_q <= eidx_q + 4'd1;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          item_q <= in_item_i;
          mag_q  <= ld_mag;
          neg_q  <= ld_ang[32];
        end
      end
      ST_REDUCE: if (mag_q >= red_cmp) mag_q <= mag_q - red_cmp;
      ST_WRAP:   z_q <= wrap_r1;
      ST_FOLD: begin
        x_q <= GAIN_Q30;
        y_q <= '0;
        if (z_q > HALF_PI_Q30) begin
          z_q <= z_q - PI_Q30;
          flip_q <= 1'b1;
        end else if (z_q < -HALF_PI_Q30) begin
          z_q <= z_q + PI_Q30;
          flip_q <= 1'b1;
        end else begin
          flip_q <= 1'b0;
        end
      end
      ST_CORDIC: begin
        if (!z_q[33]) begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - at;
        end else begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + at;
        end
      end
      ST_STORE: begin
        if (!ang_sel_q) begin
          st_q <= sin_new;
          ct_q <= cos_new;
        end else begin
          sa_q <= sin_new;
          ca_q <= cos_new;
        end
        if (item_q.func == FN_EMIT_RY) begin
          // rotation about Y as a link matrix
          for (int n = 0; n < 16; n++)
            m_q[n] <= (n == 0 || n == 10) ? cos_new :
                      (n == 2)            ? sin_new :
                      (n == 8)            ? -sin_new :
                      (n == 5 || n == 15) ? ONE : '0;
        end else if (!ang_sel_q) begin
          mag_q <= ld_mag;
          neg_q <= ld_ang[32];
        end
      end
      ST_SCALE: begin
        if (!scl_cnt_q) begin
          m_q[3] <= scale_len(33'(item_q.link_length), scale_q);
        end else begin
          ds_q    <= scale_len(d_eff, scale_q);
          m_q[0]  <= ct_q;
          m_q[1]  <= -st_q;
          m_q[2]  <= '0;
          m_q[6]  <= -sa_q;
          m_q[10] <= ca_q;
          m_q[12] <= '0;
          m_q[13] <= '0;
          m_q[14] <= '0;
          m_q[15] <= ONE;
        end
      end
      ST_MAC: begin
        // multiply one half pair, add the previous one
        if (sub_q != 3'd4) begin
          pp_q   <= pp;
          psh_q  <= {1'b0, sub_q[1]} + {1'b0, sub_q[0]};
          pneg_q <= a_op[47] ^ b_op[47];
        end
        if (sub_q == 3'd0) begin
          if (k_q == 2'd0) acc_q <= '0;
        end else if (pneg_q) begin
          acc_q <= acc_q - term;
        end else begin
          acc_q <= acc_q + term;
        end
      end
      ST_FIN: begin
        if (job_q == JOB_BUILD) m_q[btgt] <= finish(acc_q);
        else res_q[eidx_q] <= finish(acc_q);
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_q.entry_index <= eidx_q;
          out_q.entry_value <= res_q[eidx_q];
          out_q.last        <= (eidx_q == LAST_ENTRY);
        end
      end
      default: ;
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign cfg_ready_o = 1'b1;

endmodule
